// File: src/tct_pkg.sv
// ----------------------------------------------------------------------------
// tct_pkg
// Shared types, codes and constants of the touch contact tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package tct_pkg;

    localparam int TCT_NUM_SLOTS = 64;

    // Input actions.
    localparam logic [1:0] ACT_TOUCH = 2'd0;
    localparam logic [1:0] ACT_SWEEP = 2'd1;
    localparam logic [1:0] ACT_MOUSE = 2'd2;

    // Contact phases.
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_BEGIN = 2'd1;
    localparam logic [1:0] PH_MOVE  = 2'd2;
    localparam logic [1:0] PH_END   = 2'd3;

    // Event codes.
    localparam logic [1:0] EV_BEGIN = 2'd0;
    localparam logic [1:0] EV_MOVE  = 2'd1;
    localparam logic [1:0] EV_END   = 2'd2;

    localparam logic KIND_FINGER = 1'b0;
    localparam logic KIND_MOUSE  = 1'b1;

    localparam logic [6:0] MOUSE_CONTACT_ID = 7'd0;

    typedef struct packed {
        logic [6:0]  contact_id;
        logic [1:0]  event_res;
        logic        kind;
        logic [15:0] out_x;
        logic [15:0] out_y;
    } t_result;

    // Controller to datapath.
    typedef struct packed {
        logic in_ready;
        logic capture;
        logic rd_id;
        logic rd_adv;
        logic wr_touch;
        logic sweep_step;
        logic mouse_upd;
        logic flush_last;
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic       in_valid;
        logic [1:0] action;
        logic       id_ok;
        logic       ent_emit;
        logic       pend_vld;
        logic       out_free;
        logic       cnt_last;
    } t_status;

endpackage

`default_nettype wire

// File: src/tct_if.sv
// ----------------------------------------------------------------------------
// tct_if
// Valid/ready channels of the touch contact tracker: report in, event out.
// ----------------------------------------------------------------------------
`default_nettype none

interface tct_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [7:0]  report_id;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic        button_down;

    modport source (output valid, action, report_id, pos_x, pos_y, button_down,
                    input ready);
    modport sink (input valid, action, report_id, pos_x, pos_y, button_down,
                  output ready);
endinterface

interface tct_out_if;
    logic        valid;
    logic        ready;
    logic [6:0]  contact_id;
    logic [1:0]  event_res;
    logic        kind;
    logic [15:0] out_x;
    logic [15:0] out_y;
    logic        last;

    modport source (output valid, contact_id, event_res, kind, out_x, out_y, last,
                    input ready);
    modport sink (input valid, contact_id, event_res, kind, out_x, out_y, last,
                  output ready);
endinterface

`default_nettype wire

// File: src/tct_ram.sv
// ----------------------------------------------------------------------------
// tct_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

// File: src/tct_ctrl.sv
// ----------------------------------------------------------------------------
// tct_ctrl
// Sequencer: decodes the captured item and steps the slot sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module tct_ctrl import tct_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECODE = 5'b00010,
        S_TREAD  = 5'b00100,
        S_SWEEP  = 5'b01000,
        S_FLUSH  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_status.in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_status.action)
                    ACT_TOUCH: begin
                        if (i_status.id_ok) begin
                            o_cmd.rd_id = 1'b1;
                            n_state = S_TREAD;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                    ACT_SWEEP: n_state = S_SWEEP;
                    ACT_MOUSE: begin
                        o_cmd.mouse_upd = 1'b1;
                        n_state = S_FLUSH;
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_TREAD: begin
                o_cmd.wr_touch = 1'b1;
                n_state = S_FLUSH;
            end
            S_SWEEP: begin
                // An End that would displace a held event waits for the output.
                if (!(i_status.ent_emit && i_status.pend_vld && !i_status.out_free)) begin
                    o_cmd.sweep_step = 1'b1;
                    if (i_status.cnt_last) begin
                        n_state = S_FLUSH;
                    end else begin
                        o_cmd.rd_adv = 1'b1;
                    end
                end
            end
            S_FLUSH: begin
                if (!i_status.pend_vld) begin
                    n_state = S_IDLE;
                end else if (i_status.out_free) begin
                    o_cmd.flush_last = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// File: src/tct_dp.sv
// ----------------------------------------------------------------------------
// tct_dp
// Datapath: captured item, slot table, pointer state, held and output events.
// ----------------------------------------------------------------------------
`default_nettype none

module tct_dp import tct_pkg::*; #(
    parameter int NUM_TOUCH_SLOTS = TCT_NUM_SLOTS
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cmd  i_cmd,
    output t_status    o_status,
    tct_in_if.sink     i_in,
    tct_out_if.source  o_out
);

    localparam int AW = (NUM_TOUCH_SLOTS > 1) ? $clog2(NUM_TOUCH_SLOTS) : 1;
    localparam logic [AW-1:0] LAST_SLOT = AW'(NUM_TOUCH_SLOTS - 1);
    localparam logic [7:0]    ID_LIMIT  = 8'(NUM_TOUCH_SLOTS);

    // Captured item.
    logic [1:0]  r_act;
    logic [7:0]  r_id;
    logic [15:0] r_px;
    logic [15:0] r_py;
    logic        r_btn;

    logic [AW-1:0]              r_cnt;
    logic [NUM_TOUCH_SLOTS-1:0] r_vld;
    logic                       r_rd_vld;

    logic [1:0]  r_ptr_ph;
    logic [15:0] r_ptr_x;
    logic [15:0] r_ptr_y;

    t_result r_pend;
    logic    r_pend_vld;
    t_result r_out;
    logic    r_out_last;
    logic    r_ovld;

    logic [AW-1:0] slot;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [2:0]    wr_data;
    logic          wr_en;
    logic [2:0]    rd_data;
    logic [1:0]    ent_ph;
    logic          ent_seen;
    logic          ent_emit;
    logic [1:0]    sweep_ph;
    logic [1:0]    touch_ph;
    logic          out_free;
    t_result       end_res;

    assign slot    = r_id[AW-1:0];
    assign rd_addr = i_cmd.rd_id ? slot : (i_cmd.rd_adv ? r_cnt + AW'(1) : r_cnt);

    // Entries never written since reset read as idle and unseen.
    assign ent_ph   = r_rd_vld ? rd_data[2:1] : PH_IDLE;
    assign ent_seen = r_rd_vld & rd_data[0];
    assign ent_emit = !ent_seen && (ent_ph == PH_BEGIN || ent_ph == PH_MOVE);

    always_comb begin
        sweep_ph = ent_ph;
        if (!ent_seen && ent_ph != PH_IDLE) begin
            sweep_ph = (ent_ph == PH_END) ? PH_IDLE : PH_END;
        end
    end

    assign touch_ph = (ent_ph == PH_IDLE) ? PH_BEGIN : PH_MOVE;
    assign wr_en    = i_cmd.wr_touch | i_cmd.sweep_step;
    assign wr_addr  = i_cmd.wr_touch ? slot : r_cnt;
    assign wr_data  = i_cmd.wr_touch ? {touch_ph, 1'b1} : {sweep_ph, 1'b0};

    assign end_res = '{contact_id: 7'(r_cnt) + 7'd1, event_res: EV_END,
                       kind: KIND_FINGER, out_x: 16'd0, out_y: 16'd0};

    assign out_free = !r_ovld || o_out.ready;

    tct_ram #(
        .WIDTH (3),
        .DEPTH (NUM_TOUCH_SLOTS)
    ) u_slot_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_act <= i_in.action;
            r_id  <= i_in.report_id;
            r_px  <= i_in.pos_x;
            r_py  <= i_in.pos_y;
            r_btn <= i_in.button_down;
        end
        if (i_cmd.capture) begin
            r_cnt <= '0;
        end else if (i_cmd.sweep_step && r_cnt != LAST_SLOT) begin
            r_cnt <= r_cnt + AW'(1);
        end
        r_rd_vld <= r_vld[rd_addr];

        if (i_cmd.wr_touch) begin
            r_pend <= '{contact_id: 7'(slot) + 7'd1, event_res: touch_ph - 2'd1,
                        kind: KIND_FINGER, out_x: r_px, out_y: r_py};
        end else if (i_cmd.sweep_step && ent_emit) begin
            r_pend <= end_res;
        end else if (i_cmd.mouse_upd) begin
            if (r_btn) begin
                r_pend <= '{contact_id: MOUSE_CONTACT_ID,
                            event_res: (r_ptr_ph == PH_IDLE) ? EV_BEGIN : EV_MOVE,
                            kind: KIND_MOUSE, out_x: r_px, out_y: r_py};
            end else begin
                r_pend <= '{contact_id: MOUSE_CONTACT_ID, event_res: EV_END,
                            kind: KIND_MOUSE, out_x: r_ptr_x, out_y: r_ptr_y};
            end
        end

        if (i_cmd.flush_last) begin
            r_out      <= r_pend;
            r_out_last <= 1'b1;
        end else if (i_cmd.sweep_step && ent_emit && r_pend_vld) begin
            r_out      <= r_pend;
            r_out_last <= 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= '0;
            r_ptr_ph   <= PH_IDLE;
            r_ptr_x    <= '0;
            r_ptr_y    <= '0;
            r_pend_vld <= 1'b0;
            r_ovld     <= 1'b0;
        end else begin
            if (wr_en) begin
                r_vld[wr_addr] <= 1'b1;
            end

            if (i_cmd.mouse_upd) begin
                if (r_btn) begin
                    r_ptr_x  <= r_px;
                    r_ptr_y  <= r_py;
                    r_ptr_ph <= (r_ptr_ph == PH_IDLE) ? PH_BEGIN : PH_MOVE;
                end else if (r_ptr_ph == PH_END) begin
                    r_ptr_ph <= PH_IDLE;
                end else if (r_ptr_ph != PH_IDLE) begin
                    r_ptr_ph <= PH_END;
                end
            end

            if (i_cmd.wr_touch || (i_cmd.sweep_step && ent_emit)) begin
                r_pend_vld <= 1'b1;
            end else if (i_cmd.mouse_upd) begin
                r_pend_vld <= r_btn || r_ptr_ph == PH_BEGIN || r_ptr_ph == PH_MOVE;
            end else if (i_cmd.flush_last) begin
                r_pend_vld <= 1'b0;
            end

            if (i_cmd.flush_last || (i_cmd.sweep_step && ent_emit && r_pend_vld)) begin
                r_ovld <= 1'b1;
            end else if (o_out.ready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    assign i_in.ready        = i_cmd.in_ready;
    assign o_out.valid       = r_ovld;
    assign o_out.contact_id  = r_out.contact_id;
    assign o_out.event_res   = r_out.event_res;
    assign o_out.kind        = r_out.kind;
    assign o_out.out_x       = r_out.out_x;
    assign o_out.out_y       = r_out.out_y;
    assign o_out.last        = r_out_last;

    assign o_status.in_valid = i_in.valid;
    assign o_status.action   = r_act;
    assign o_status.id_ok    = r_id < ID_LIMIT;
    assign o_status.ent_emit = ent_emit;
    assign o_status.pend_vld = r_pend_vld;
    assign o_status.out_free = out_free;
    assign o_status.cnt_last = r_cnt == LAST_SLOT;

endmodule

`default_nettype wire

// File: src/touch_contact_tracker.sv
// ----------------------------------------------------------------------------
// touch_contact_tracker
// Turns raw touch reports, frame sweeps and mouse samples into contact events.
// ----------------------------------------------------------------------------
//  channel  direction  port   carries
//  report   in         i_in   action, report_id, pos_x, pos_y, button_down
//  event    out        o_out  contact_id, event_res, kind, out_x, out_y, last
//
//  One item at a time. A frame sweep reads one slot per cycle, unless the
//  output stalls it, through the single read port of the slot RAM.
//  Reset is synchronous; the slot table needs no clearing pass, valid flops
//  mark entries written since reset. Each End found by a sweep is held until
//  the next one is found, so that the final one carries last; a full output
//  stalls the sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module touch_contact_tracker import tct_pkg::*; #(
    parameter int NUM_TOUCH_SLOTS = TCT_NUM_SLOTS
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    tct_in_if.sink    i_in,
    tct_out_if.source o_out
);

    t_cmd    cmd;
    t_status status;

    tct_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_cmd    (cmd)
    );

    tct_dp #(
        .NUM_TOUCH_SLOTS (NUM_TOUCH_SLOTS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_status (status),
        .i_in     (i_in),
        .o_out    (o_out)
    );

endmodule

`default_nettype wire

// File: sim/touch_contact_tracker_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// touch_contact_tracker_tb
// Drives touch reports, frame sweeps and mouse samples into the tracker and
// checks every contact event against a behavioral model of the slot table
// and the pointer. Both channels idle and stall at random.
// ----------------------------------------------------------------------------

module touch_contact_tracker_tb;
    import tct_pkg::*;

    localparam logic [1:0] ACT_UNKNOWN  = 2'd3;
    localparam int         ITEM_TARGET  = 270;
    localparam int         TAIL_CYCLES  = 200;
    // Worst case is about 300 items times 64 events, each behind the longest
    // sink stall; the limit is a few times that.
    localparam int         LIMIT_CYCLES = 3_000_000;

    typedef struct packed {
        logic [6:0]  contact_id;
        logic [1:0]  event_res;
        logic        kind;
        logic [15:0] out_x;
        logic [15:0] out_y;
        logic        last;
    } t_contact_event;

    logic i_clk = 1'b0;
    logic i_rst_n;

    tct_in_if  in_ch ();
    tct_out_if out_ch ();

    touch_contact_tracker dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #4 i_clk = ~i_clk;

    // Model state.
    logic [1:0]  slot_phase [0:TCT_NUM_SLOTS-1];
    logic        slot_seen [0:TCT_NUM_SLOTS-1];
    logic [1:0]  pointer_phase;
    logic [15:0] pointer_x;
    logic [15:0] pointer_y;

    t_contact_event pending_events[$];

    int  fail_count  = 0;
    int  item_count  = 0;
    int  cycle_count = 0;
    int  sink_hold   = 0;
    bit  src_steady  = 1'b0;
    bit  sink_steady = 1'b0;

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic t_contact_event make_event(input logic [6:0] cid,
                                                  input logic [1:0] ev,
                                                  input logic kd,
                                                  input logic [15:0] x,
                                                  input logic [15:0] y);
        t_contact_event e;
        e.contact_id = cid;
        e.event_res  = ev;
        e.kind       = kd;
        e.out_x      = x;
        e.out_y      = y;
        e.last       = 1'b0;
        return e;
    endfunction

    // Applies one accepted item to the model and queues the events it causes.
    task automatic track_contacts(input logic [1:0] act, input logic [7:0] id,
                                  input logic [15:0] x, input logic [15:0] y,
                                  input logic btn);
        t_contact_event evs[$];
        logic           was_idle;
        case (act)
            ACT_TOUCH: begin
                if (id < TCT_NUM_SLOTS) begin
                    was_idle = (slot_phase[id] == PH_IDLE);
                    slot_phase[id] = was_idle ? PH_BEGIN : PH_MOVE;
                    slot_seen[id]  = 1'b1;
                    evs.insert(evs.size(),
                               make_event(7'(id + 1), was_idle ? EV_BEGIN : EV_MOVE,
                                          KIND_FINGER, x, y));
                end
            end
            ACT_SWEEP: begin
                for (int s = 0; s < TCT_NUM_SLOTS; s++) begin
                    if (!slot_seen[s] && slot_phase[s] != PH_IDLE) begin
                        if (slot_phase[s] != PH_END) begin
                            slot_phase[s] = PH_END;
                            evs.insert(evs.size(),
                                       make_event(7'(s + 1), EV_END, KIND_FINGER,
                                                  16'd0, 16'd0));
                        end else begin
                            slot_phase[s] = PH_IDLE;
                        end
                    end
                    slot_seen[s] = 1'b0;
                end
            end
            ACT_MOUSE: begin
                if (btn) begin
                    pointer_x = x;
                    pointer_y = y;
                    was_idle  = (pointer_phase == PH_IDLE);
                    pointer_phase = was_idle ? PH_BEGIN : PH_MOVE;
                    evs.insert(evs.size(),
                               make_event(MOUSE_CONTACT_ID,
                                          was_idle ? EV_BEGIN : EV_MOVE,
                                          KIND_MOUSE, pointer_x, pointer_y));
                end else if (pointer_phase == PH_END) begin
                    pointer_phase = PH_IDLE;
                end else if (pointer_phase != PH_IDLE) begin
                    pointer_phase = PH_END;
                    evs.insert(evs.size(),
                               make_event(MOUSE_CONTACT_ID, EV_END, KIND_MOUSE,
                                          pointer_x, pointer_y));
                end
            end
            default: ;
        endcase
        if (evs.size() > 0) evs[evs.size() - 1].last = 1'b1;
        foreach (evs[k]) pending_events.insert(pending_events.size(), evs[k]);
    endtask

    // Sends one item; valid stays high into the next item when there is no gap.
    task automatic send_item(input logic [1:0] act, input logic [7:0] id,
                             input logic [15:0] x, input logic [15:0] y,
                             input logic btn);
        int gap;
        gap = src_steady ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_ch.valid       <= 1'b1;
        in_ch.action      <= act;
        in_ch.report_id   <= id;
        in_ch.pos_x       <= x;
        in_ch.pos_y       <= y;
        in_ch.button_down <= btn;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        track_contacts(act, id, x, y, btn);
        if (!(act == ACT_UNKNOWN || (act == ACT_TOUCH && id >= TCT_NUM_SLOTS)))
            item_count++;
    endtask

    task automatic send_sweep();
        send_item(ACT_SWEEP, 8'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
    endtask

    // Holds the report channel idle until every queued event has come out.
    task automatic pause_reports();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (pending_events.size() != 0) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : check_event
        t_contact_event want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_events.size() == 0) begin
                $display("%0t ns: unexpected event, expected none, got id %0d event %0d",
                         $time, out_ch.contact_id, out_ch.event_res);
                fail_count++;
            end else begin
                want = pending_events.pop_front();
                check_field("contact_id", 16'(want.contact_id), 16'(out_ch.contact_id));
                check_field("event_res", 16'(want.event_res), 16'(out_ch.event_res));
                check_field("kind", 16'(want.kind), 16'(out_ch.kind));
                check_field("out_x", want.out_x, out_ch.out_x);
                check_field("out_y", want.out_y, out_ch.out_y);
                check_field("last", 16'(want.last), 16'(out_ch.last));
            end
        end
    end

    // Event channel back-pressure.
    initial out_ch.ready = 1'b0;

    always @(negedge i_clk) begin
        if (sink_hold > 0) begin
            out_ch.ready <= 1'b0;
            sink_hold = sink_hold - 1;
        end else begin
            out_ch.ready <= 1'b1;
            if (!sink_steady) sink_hold = pick_gap();
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("status: fail");
            $finish;
        end
    end

    // Begin, repeat in a frame, invalid ids, report on a slot in End, and
    // empty sweeps.
    task automatic test_touch_phases();
        send_item(ACT_TOUCH, 8'd0, 16'h0000, 16'h0000, 1'b0);
        send_item(ACT_TOUCH, 8'd63, 16'hFFFF, 16'hFFFF, 1'b1);
        send_item(ACT_TOUCH, 8'd64, 16'h1111, 16'h2222, 1'b0);
        send_item(ACT_TOUCH, 8'd255, 16'hFFFF, 16'hFFFF, 1'b1);
        send_item(ACT_TOUCH, 8'd128, 16'h5555, 16'hAAAA, 1'b0);
        send_item(ACT_TOUCH, 8'd0, 16'h1234, 16'hABCD, 1'b0);
        send_sweep();
        send_sweep();
        send_item(ACT_TOUCH, 8'd0, 16'd5, 16'd6, 1'b0);
        send_sweep();
        send_sweep();
        send_sweep();
        send_sweep();
    endtask

    // Release when idle, held while in End, and release while in End.
    task automatic test_mouse_pointer();
        send_item(ACT_MOUSE, 8'd0, 16'd9, 16'd9, 1'b0);
        send_item(ACT_MOUSE, 8'd0, 16'h0000, 16'h0000, 1'b1);
        send_item(ACT_MOUSE, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1);
        send_item(ACT_MOUSE, 8'd0, 16'd1, 16'd2, 1'b0);
        send_item(ACT_MOUSE, 8'd0, 16'd7, 16'd8, 1'b1);
        send_item(ACT_MOUSE, 8'd0, 16'd3, 16'd4, 1'b0);
        send_item(ACT_MOUSE, 8'd0, 16'd3, 16'd4, 1'b0);
        send_item(ACT_MOUSE, 8'd0, 16'hA5A5, 16'h5A5A, 1'b1);
        send_item(ACT_MOUSE, 8'd0, 16'd0, 16'd0, 1'b0);
    endtask

    task automatic test_unknown_action();
        send_item(ACT_UNKNOWN, 8'd5, 16'd100, 16'd200, 1'b0);
        send_item(ACT_UNKNOWN, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1);
    endtask

    // Every slot touched in one frame, then a sweep that closes the frame and a second that ends all 64.
    task automatic test_full_frame();
        int order [0:TCT_NUM_SLOTS-1];
        int j;
        int t;
        for (int s = 0; s < TCT_NUM_SLOTS; s++) order[s] = s;
        for (int s = TCT_NUM_SLOTS - 1; s > 0; s--) begin
            j = $urandom_range(0, s);
            t = order[s];
            order[s] = order[j];
            order[j] = t;
        end
        for (int s = 0; s < TCT_NUM_SLOTS; s++)
            send_item(ACT_TOUCH, 8'(order[s]), 16'($urandom), 16'($urandom), 1'($urandom));
        send_sweep();
        send_sweep();
        send_sweep();
    endtask

    // Frames of reports on a small set of live ids, mouse samples and noise,
    // each closed by a sweep.
    task automatic test_random_frames();
        logic [7:0] live_ids [0:7];
        logic [7:0] id;
        int         n;
        int         r;
        bit         paused;
        paused = 1'b0;
        for (int k = 0; k < 8; k++) live_ids[k] = 8'($urandom_range(0, TCT_NUM_SLOTS - 1));
        while (item_count < ITEM_TARGET) begin
            src_steady  = ($urandom_range(0, 4) == 0);
            sink_steady = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 3) == 0)
                live_ids[$urandom_range(0, 7)] = 8'($urandom_range(0, TCT_NUM_SLOTS - 1));
            n = $urandom_range(0, 10);
            for (int k = 0; k < n; k++) begin
                r = $urandom_range(0, 99);
                if (r < 60) begin
                    id = live_ids[$urandom_range(0, 7)];
                    send_item(ACT_TOUCH, id, 16'($urandom), 16'($urandom), 1'($urandom));
                end else if (r < 70) begin
                    id = 8'($urandom_range(0, TCT_NUM_SLOTS - 1));
                    send_item(ACT_TOUCH, id, 16'($urandom), 16'($urandom), 1'($urandom));
                end else if (r < 76) begin
                    id = 8'($urandom_range(TCT_NUM_SLOTS, 255));
                    send_item(ACT_TOUCH, id, 16'($urandom), 16'($urandom), 1'($urandom));
                end else if (r < 95) begin
                    send_item(ACT_MOUSE, 8'($urandom), 16'($urandom), 16'($urandom),
                              ($urandom_range(0, 9) < 7));
                end else begin
                    send_item(ACT_UNKNOWN, 8'($urandom), 16'($urandom), 16'($urandom),
                              1'($urandom));
                end
            end
            send_sweep();
            if (!paused && item_count >= ITEM_TARGET / 2) begin
                pause_reports();
                paused = 1'b1;
            end
        end
        src_steady  = 1'b0;
        sink_steady = 1'b0;
    endtask

    initial begin
        i_rst_n           = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.action      = ACT_TOUCH;
        in_ch.report_id   = 8'd0;
        in_ch.pos_x       = 16'd0;
        in_ch.pos_y       = 16'd0;
        in_ch.button_down = 1'b0;
        for (int s = 0; s < TCT_NUM_SLOTS; s++) begin
            slot_phase[s] = PH_IDLE;
            slot_seen[s]  = 1'b0;
        end
        pointer_phase = PH_IDLE;
        pointer_x     = 16'd0;
        pointer_y     = 16'd0;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_touch_phases();
        test_mouse_pointer();
        test_unknown_action();
        test_full_frame();
        test_random_frames();

        pause_reports();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
